### rtl/core/qtrs_pkg.sv
// ----------------------------------------------------------------------------
// qtrs_pkg: shared types and constants of the quaternion TRS matrix builder
// Field widths, fixed-point constants and the entry-unit control group.
// ----------------------------------------------------------------------------
package qtrs_pkg;

    localparam int QUAT_W    = 16;          // Q2.14 quaternion component
    localparam int POS_W     = 32;          // Q16.16 translation
    localparam int SCALE_W   = 24;          // Q8.16 scale
    localparam int ENT_W     = 24;          // Q8.16 matrix entry
    localparam int QPROD_W   = 2 * QUAT_W;  // quaternion product, Q.28
    localparam int ROT_W     = QPROD_W + 1; // rotation entry held in Q.27
    localparam int MUL_W     = ROT_W + SCALE_W;
    localparam int FRAC_SH   = 27;          // Q.43 product down to Q8.16
    localparam int QUO_W     = MUL_W - FRAC_SH;
    localparam int N_ENT     = 9;
    localparam int N_AXIS    = 3;

    localparam int IN_TDATA_W  = 4 * QUAT_W + 3 * POS_W + 3 * SCALE_W;
    localparam int OUT_TDATA_W = N_ENT * ENT_W + 3 * POS_W;

    localparam logic signed [ROT_W-1:0] ROT_ONE   = ROT_W'(1) <<< FRAC_SH;
    localparam logic signed [MUL_W-1:0] RND_HALF  = MUL_W'(1) <<< (FRAC_SH - 1);
    localparam logic signed [ENT_W-1:0] ENT_MAX   = {1'b0, {(ENT_W-1){1'b1}}};
    localparam logic signed [ENT_W-1:0] ENT_MIN   = {1'b1, {(ENT_W-1){1'b0}}};

    typedef struct packed {
        logic load_prod;   // take a new product into the multiply stage
        logic load_out;    // take a new rounded entry into the output stage
    } t_entry_ctl;

endpackage

### rtl/core/qtrs_entry.sv
// ----------------------------------------------------------------------------
// qtrs_entry: scale, round and saturate one matrix entry
// Two register stages: signed multiply, then round to nearest and clamp.
// ----------------------------------------------------------------------------
module qtrs_entry
    import qtrs_pkg::*;
(
    input  logic                      i_clk,
    input  t_entry_ctl                i_ctl,
    input  logic signed [ROT_W-1:0]   i_rot,
    input  logic signed [SCALE_W-1:0] i_scale,
    output logic signed [ENT_W-1:0]   o_entry
);

    logic signed [MUL_W-1:0] r_prod;
    logic signed [MUL_W-1:0] n_prod;
    logic signed [MUL_W-1:0] w_rnd;
    logic signed [QUO_W-1:0] w_quo;
    logic signed [ENT_W-1:0] r_entry;
    logic signed [ENT_W-1:0] n_entry;

    assign n_prod = i_rot * i_scale;

    // round half up, then clamp to the entry range
    always_comb begin
        w_rnd = r_prod + RND_HALF;
        w_quo = w_rnd[MUL_W-1:FRAC_SH];
        if (w_quo > QUO_W'(ENT_MAX)) begin
            n_entry = ENT_MAX;
        end else if (w_quo < QUO_W'(ENT_MIN)) begin
            n_entry = ENT_MIN;
        end else begin
            n_entry = w_quo[ENT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= n_prod;
        end
        if (i_ctl.load_out) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### rtl/core/quaternion_trs_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_trs_matrix: Translate*Rotate*Scale matrix from a quaternion
// An accepted input word passes the product, rotation, multiply and round stages to its result word.
// Throughput: one word per cycle while m_axis_tready is not held low; the four-stage pipeline closes up bubbles.
// The stage depth is set by the 33x24 scale multiply of each entry.
// Reset: synchronous, active low; clears every stage valid bit only.
// ----------------------------------------------------------------------------
module quaternion_trs_matrix
    import qtrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side, fields from bit 0 up: quat_x, quat_y, quat_z, quat_w,
    // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // master side, fields from bit 0 up: row0_col0, row0_col1, row0_col2,
    // row1_col0, row1_col1, row1_col2, row2_col0, row2_col1, row2_col2,
    // trans_x, trans_y, trans_z
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int POS_LO   = 4 * QUAT_W;
    localparam int SCALE_LO = POS_LO + 3 * POS_W;
    localparam int TRANS_LO = N_ENT * ENT_W;

    // Stage enables: a stage loads when it is empty or its successor loads.
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_en4 = !r_v4 || m_axis_tready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign s_axis_tready = w_en1;

    // Unpack the input word.
    logic signed [QUAT_W-1:0] w_qx, w_qy, w_qz, w_qw;

    assign w_qx = s_axis_tdata[0*QUAT_W +: QUAT_W];
    assign w_qy = s_axis_tdata[1*QUAT_W +: QUAT_W];
    assign w_qz = s_axis_tdata[2*QUAT_W +: QUAT_W];
    assign w_qw = s_axis_tdata[3*QUAT_W +: QUAT_W];

    // Stage 1: the nine quaternion products, exact in Q.28.
    logic signed [QPROD_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_xw, r_yw, r_zw;
    logic signed [SCALE_W-1:0] r_scale1 [N_AXIS];
    logic        [3*POS_W-1:0] r_pos1;

    // Stage 2: rotation entries, held in Q.27 (twice the Q.28 value).
    logic signed [ROT_W-1:0]   r_rot [N_ENT];
    logic signed [ROT_W-1:0]   n_rot [N_ENT];
    logic signed [SCALE_W-1:0] r_scale2 [N_AXIS];
    logic        [3*POS_W-1:0] r_pos2;

    // Stages 3 and 4 live in the entry units; carry the translation beside them.
    logic        [3*POS_W-1:0] r_pos3;
    logic        [3*POS_W-1:0] r_pos4;

    always_comb begin
        n_rot[0] = ROT_ONE - (ROT_W'(r_yy) + ROT_W'(r_zz));
        n_rot[1] = ROT_W'(r_xy) - ROT_W'(r_zw);
        n_rot[2] = ROT_W'(r_xz) + ROT_W'(r_yw);
        n_rot[3] = ROT_W'(r_xy) + ROT_W'(r_zw);
        n_rot[4] = ROT_ONE - (ROT_W'(r_xx) + ROT_W'(r_zz));
        n_rot[5] = ROT_W'(r_yz) - ROT_W'(r_xw);
        n_rot[6] = ROT_W'(r_xz) - ROT_W'(r_yw);
        n_rot[7] = ROT_W'(r_yz) + ROT_W'(r_xw);
        n_rot[8] = ROT_ONE - (ROT_W'(r_xx) + ROT_W'(r_yy));
    end

    // Valid bits: advance with their stage, clear on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload of stages 1 and 2, plus the translation of 3 and 4.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_xx   <= w_qx * w_qx;
            r_yy   <= w_qy * w_qy;
            r_zz   <= w_qz * w_qz;
            r_xy   <= w_qx * w_qy;
            r_xz   <= w_qx * w_qz;
            r_yz   <= w_qy * w_qz;
            r_xw   <= w_qx * w_qw;
            r_yw   <= w_qy * w_qw;
            r_zw   <= w_qz * w_qw;
            r_pos1 <= s_axis_tdata[POS_LO +: 3*POS_W];
            for (int a = 0; a < N_AXIS; a++) begin
                r_scale1[a] <= s_axis_tdata[SCALE_LO + a*SCALE_W +: SCALE_W];
            end
        end
        if (w_en2) begin
            r_rot    <= n_rot;
            r_scale2 <= r_scale1;
            r_pos2   <= r_pos1;
        end
        if (w_en3) begin
            r_pos3 <= r_pos2;
        end
        if (w_en4) begin
            r_pos4 <= r_pos3;
        end
    end

    // Entry units: multiply by the scale of their column, then round and clamp.
    t_entry_ctl w_ctl;

    assign w_ctl.load_prod = w_en3;
    assign w_ctl.load_out  = w_en4;

    genvar k;
    generate
        for (k = 0; k < N_ENT; k++) begin : g_entry
            qtrs_entry u_entry (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_rot   (r_rot[k]),
                .i_scale (r_scale2[k % N_AXIS]),
                .o_entry (m_axis_tdata[k*ENT_W +: ENT_W])
            );
        end
    endgenerate

    assign m_axis_tdata[TRANS_LO +: 3*POS_W] = r_pos4;
    assign m_axis_tvalid = r_v4;

endmodule

### rtl/core/qtrs_checker.sv
// ----------------------------------------------------------------------------
// qtrs_checker: port-level checks of the quaternion TRS matrix builder
// Output handshake, reset, latency of the translation and the identity case.
// ----------------------------------------------------------------------------
module qtrs_checker
    import qtrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int POS_LO   = 4 * QUAT_W;
    localparam int SCALE_LO = POS_LO + 3 * POS_W;
    localparam int TRANS_LO = N_ENT * ENT_W;

    localparam logic [4*QUAT_W-1:0] QUAT_UNIT = {16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    localparam logic [SCALE_W-1:0]  SCALE_ONE = 24'h010000;

    // hold a stalled result word
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word present after reset");

    // with no back-pressure the accepted translation appears unaltered on the output word
    a_trans_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready
        |=> m_axis_tvalid
            && m_axis_tdata[TRANS_LO +: 3*POS_W] == $past(s_axis_tdata[POS_LO +: 3*POS_W], 4))
        else $error("translation late or altered");

    // identity rotation with unit x scale gives exactly one in row0_col0
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[4*QUAT_W-1:0] == QUAT_UNIT
            && s_axis_tdata[SCALE_LO +: SCALE_W] == SCALE_ONE)
            ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tdata[ENT_W-1:0] == SCALE_ONE)
        else $error("identity rotation gives wrong diagonal entry");

endmodule

bind quaternion_trs_matrix qtrs_checker u_qtrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
